FILE: hw/rtl/cht_pkg.sv
// Shared constants, types and state codes for the coalesced hash table.
// Used by cht_slots, coalesced_hash_table and its testbench; depends on nothing else.
package cht_pkg;

  // Table geometry; the home slot is key mod TABLE_SIZE, kept a power of two
  localparam int TABLE_SIZE = 8;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int LINK_W     = SLOT_W + 1;
  localparam int STEP_W     = $clog2(TABLE_SIZE + 1);
  localparam int KEY_W      = 31;
  localparam int OUT_SLOT_W = 3;

  // A link at or above TABLE_SIZE marks the end of a chain
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(TABLE_SIZE);

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_FIND_WALK,
    S_SCAN,
    S_FINISH
  } state_t;

  // Write request into the slot arrays
  typedef struct packed {
    logic              key_we;
    logic [SLOT_W-1:0] key_addr;
    logic [KEY_W-1:0]  key_val;
    logic              link_we;
    logic [SLOT_W-1:0] link_addr;
    logic [SLOT_W-1:0] link_val;
  } cht_wr_t;

  // Read view of the slot arrays
  typedef struct packed {
    logic                  used;
    logic [KEY_W-1:0]      key;
    logic                  link_null;
    logic [SLOT_W-1:0]     link_next;
    logic                  fp_used;
    logic [TABLE_SIZE-1:0] used_vec;
  } cht_rd_t;

endpackage

FILE: hw/rtl/cht_slots.sv
// Slot storage of the hash table: keys, used bits and chain links.
// Depends on cht_pkg for geometry and the read/write structs.
module cht_slots
  import cht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cht_wr_t           wr,
  input  logic [SLOT_W-1:0] rd_addr,
  input  logic [SLOT_W-1:0] fp_addr,
  output cht_rd_t           rd
);

  logic [KEY_W-1:0]      key_r  [TABLE_SIZE];
  logic [LINK_W-1:0]     link_r [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] used_r;
  logic [LINK_W-1:0]     link_sel;

  // Store keys; no reset, a key is read only from a used slot
  always_ff @(posedge clk) begin
    if (wr.key_we) begin
      key_r[wr.key_addr] <= wr.key_val;
    end
  end

  // Mark slots used and update chain links
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        link_r[i] <= LINK_NULL;
      end
    end else begin
      if (wr.key_we) begin
        used_r[wr.key_addr] <= 1'b1;
      end
      if (wr.link_we) begin
        link_r[wr.link_addr] <= {1'b0, wr.link_val};
      end
    end
  end

  // Read one slot at the walk address, the used bit at the free pointer and all used bits
  always_comb begin
    link_sel     = link_r[rd_addr];
    rd.used      = used_r[rd_addr];
    rd.key       = key_r[rd_addr];
    rd.link_null = (link_sel >= LINK_NULL);
    rd.link_next = link_sel[SLOT_W-1:0];
    rd.fp_used   = used_r[fp_addr];
    rd.used_vec  = used_r;
  end

endmodule

FILE: hw/rtl/coalesced_hash_table.sv
// Top level of the coalesced hash table: request sequencer and result register.
// Depends on cht_pkg and cht_slots.
//
//   channel | ports                        | direction
//   in      | in_valid in_stall in_req_type in_key | request item in
//   out     | out_valid out_stall out_status out_slot | result item out
//
// An item holds the block from its accept to the next accept: each chain step
// goes through the walk read port and compare, an insert then writes the link,
// and then the free pointer scans down past used slots step by step.
// A full-table insert skips the walk and scan; a home-slot hit ends the walk at once.
// Reset clears used bits and links directly; no clearing pass.
// A stalled result is held in the output register; the next item is taken
// meanwhile and waits at its last step until the register frees.
module coalesced_hash_table
  import cht_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_req_type,
  input  logic [KEY_W-1:0]      in_key,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [OUT_SLOT_W-1:0] out_slot
);

  state_t                state_r, state_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [SLOT_W-1:0]     cur_r, cur_nxt;
  logic [SLOT_W-1:0]     dest_r, dest_nxt;
  logic [STEP_W-1:0]     steps_r, steps_nxt;
  logic [SLOT_W-1:0]     fp_r, fp_nxt;
  logic                  exhausted_r, exhausted_nxt;
  status_t               res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]     res_slot_r, res_slot_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [OUT_SLOT_W-1:0] out_slot_r, out_slot_nxt;

  logic [SLOT_W-1:0]     home_in;
  logic [SLOT_W-1:0]     rd_addr;
  logic                  accept;
  cht_wr_t               wr;
  cht_rd_t               rd;

  cht_slots u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_addr (rd_addr),
    .fp_addr (fp_r),
    .rd      (rd)
  );

  assign home_in  = SLOT_W'(in_key % TABLE_SIZE);
  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign rd_addr  = (state_r == S_IDLE) ? home_in : cur_r;

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

  // Hold sequencer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fp_r        <= SLOT_W'(TABLE_SIZE - 1);
      exhausted_r <= 1'b0;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      fp_r        <= fp_nxt;
      exhausted_r <= exhausted_nxt;
      out_valid_r <= out_valid_nxt;
      steps_r     <= steps_nxt;
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    cur_r        <= cur_nxt;
    dest_r       <= dest_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  // Sequence one request: walk the chain, update links, scan the free pointer
  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    cur_nxt        = cur_r;
    dest_nxt       = dest_r;
    steps_nxt      = steps_r;
    fp_nxt         = fp_r;
    exhausted_nxt  = exhausted_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    wr             = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt   = in_key;
          cur_nxt   = home_in;
          steps_nxt = '0;
          if (in_req_type) begin
            state_nxt = S_FIND_WALK;
          end else if (exhausted_r) begin
            res_status_nxt = ST_FULL;
            res_slot_nxt   = '0;
            state_nxt      = S_FINISH;
          end else if (!rd.used) begin
            // Empty home slot takes the key directly
            wr.key_we   = 1'b1;
            wr.key_addr = home_in;
            wr.key_val  = in_key;
            dest_nxt    = home_in;
            state_nxt   = S_SCAN;
          end else begin
            dest_nxt  = fp_r;
            state_nxt = S_INS_WALK;
          end
        end
      end

      S_INS_WALK: begin
        if (steps_r < STEP_W'(TABLE_SIZE) && !rd.link_null) begin
          cur_nxt   = rd.link_next;
          steps_nxt = steps_r + STEP_W'(1);
        end else begin
          // Link the chain tail to the free slot and store the key there
          wr.link_we   = 1'b1;
          wr.link_addr = cur_r;
          wr.link_val  = dest_r;
          wr.key_we    = 1'b1;
          wr.key_addr  = dest_r;
          wr.key_val   = key_r;
          state_nxt    = S_SCAN;
        end
      end

      S_FIND_WALK: begin
        if (steps_r >= STEP_W'(TABLE_SIZE)) begin
          res_status_nxt = ST_MISSING;
          res_slot_nxt   = '0;
          state_nxt      = S_FINISH;
        end else if (rd.used && rd.key == key_r) begin
          res_status_nxt = ST_FOUND;
          res_slot_nxt   = cur_r;
          state_nxt      = S_FINISH;
        end else if (rd.link_null) begin
          res_status_nxt = ST_MISSING;
          res_slot_nxt   = '0;
          state_nxt      = S_FINISH;
        end else begin
          cur_nxt   = rd.link_next;
          steps_nxt = steps_r + STEP_W'(1);
        end
      end

      S_SCAN: begin
        // Step the free pointer down past used slots
        if (!exhausted_r && rd.fp_used) begin
          if (fp_r == '0) begin
            exhausted_nxt = 1'b1;
          end else begin
            fp_nxt = fp_r - SLOT_W'(1);
          end
        end else begin
          res_status_nxt = ST_INSERTED;
          res_slot_nxt   = dest_r;
          state_nxt      = S_FINISH;
        end
      end

      S_FINISH: begin
        // Load the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = OUT_SLOT_W'(res_slot_r);
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // A table marked full has every slot used
  a_full_means_used: assert property (@(posedge clk) disable iff (!rst_n)
    exhausted_r |-> (&rd.used_vec))
    else $error("free pointer exhausted with an empty slot");

  // A dropped insert is reported only on a full table
  a_drop_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && res_status_r == ST_FULL) |-> exhausted_r)
    else $error("insert dropped while slots remain");

  // Chain walks never exceed the step bound
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= STEP_W'(TABLE_SIZE))
    else $error("chain walk ran past its bound");

  // A found result names a used slot holding the key
  a_found_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIND_WALK && state_nxt == S_FINISH && res_status_nxt == ST_FOUND)
      |-> (rd.used && rd.key == key_r))
    else $error("find reported a slot that does not hold the key");

endmodule

FILE: verif/coalesced_hash_table_tb.sv
// Self-checking testbench for coalesced_hash_table: inserts and finds on the
// 8-slot chained table, checked against a behavioral table model kept here.
// Depends on cht_pkg and the RTL of coalesced_hash_table only.
`timescale 1ns / 1ps

module coalesced_hash_table_tb;
  import cht_pkg::*;

  localparam bit REQ_INSERT  = 1'b0;
  localparam bit REQ_FIND    = 1'b1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 2 * TABLE_SIZE + 8;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  typedef struct {
    status_t                status;
    logic [OUT_SLOT_W-1:0]  slot;
  } result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_req_type;
  logic [KEY_W-1:0]      in_key;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            out_status;
  logic [OUT_SLOT_W-1:0] out_slot;

  // Table model state
  logic [KEY_W-1:0] slot_keys [TABLE_SIZE];
  bit               slot_taken [TABLE_SIZE];
  int               next_slot [TABLE_SIZE];
  int               free_slot;
  bit               slots_exhausted;

  result_t          pending_results [$];
  logic [KEY_W-1:0] stored_keys [$];
  result_t          oldest;
  int               mismatch_count;
  int               results_checked;
  int               cycle_count;
  int               hold_request;
  int               n_insert, n_find, n_full, n_found, n_missing;

  coalesced_hash_table dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_key      (in_key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_status  (out_status),
    .out_slot    (out_slot)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  function automatic void clear_table();
    for (int i = 0; i < TABLE_SIZE; i++) begin
      slot_keys[i]  = '0;
      slot_taken[i] = 1'b0;
      next_slot[i]  = TABLE_SIZE;
    end
    free_slot       = TABLE_SIZE - 1;
    slots_exhausted = 1'b0;
  endfunction

  // Apply one request to the table model and return the result it produces
  function automatic result_t hash_table_outcome(input bit find_op,
                                                 input logic [KEY_W-1:0] key);
    result_t res;
    int      cur;
    int      dest;
    cur        = int'(key % TABLE_SIZE);
    res.status = ST_MISSING;
    res.slot   = '0;
    if (find_op) begin
      // Walk the chain from the home slot, bounded by the table size
      for (int steps = 0; steps < TABLE_SIZE; steps++) begin
        if (slot_taken[cur] && slot_keys[cur] == key) begin
          res.status = ST_FOUND;
          res.slot   = OUT_SLOT_W'(cur);
          return res;
        end
        if (next_slot[cur] >= TABLE_SIZE) break;
        cur = next_slot[cur];
      end
      return res;
    end
    if (slots_exhausted || free_slot >= TABLE_SIZE) begin
      res.status = ST_FULL;
      return res;
    end
    if (!slot_taken[cur]) begin
      dest = cur;
    end else begin
      // Take the free slot and hang it off the tail of the home chain
      dest = free_slot;
      for (int steps = 0; steps < TABLE_SIZE && next_slot[cur] < TABLE_SIZE; steps++)
        cur = next_slot[cur];
      next_slot[cur] = dest;
    end
    slot_keys[dest]  = key;
    slot_taken[dest] = 1'b1;
    // Advance the free pointer downward past used slots
    while (!slots_exhausted && free_slot < TABLE_SIZE && slot_taken[free_slot]) begin
      if (free_slot == 0) slots_exhausted = 1'b1;
      else free_slot--;
    end
    res.status = ST_INSERTED;
    res.slot   = OUT_SLOT_W'(dest);
    return res;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    int pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return KEY_MAX;
    return KEY_W'($urandom());
  endfunction

  // Offer one item and hold it until accepted, then predict its result
  task automatic send_request(input bit find_op, input logic [KEY_W-1:0] key);
    result_t want;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_req_type <= find_op;
    in_key      <= key;
    do @(posedge clk); while (in_stall);
    want = hash_table_outcome(find_op, key);
    pending_results.push_back(want);
    if (find_op) n_find++;
    else n_insert++;
    case (want.status)
      ST_INSERTED: stored_keys.push_back(key);
      ST_FULL:     n_full++;
      ST_FOUND:    n_found++;
      default:     n_missing++;
    endcase
  endtask

  task automatic idle_cycles(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic wait_drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Check each accepted result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d slot=%0d",
                                  out_status, out_slot));
      end else begin
        oldest = pending_results.pop_front();
        if (out_status !== oldest.status)
          report_mismatch($sformatf("status got %0d want %s", out_status,
                                    oldest.status.name()));
        if (out_slot !== oldest.slot)
          report_mismatch($sformatf("slot got %0d want %0d (%s)", out_slot,
                                    oldest.slot, oldest.status.name()));
      end
    end
  end

  // Result-side stall: long hold-offs on request, otherwise a shifting pattern
  initial begin
    int hold_left;
    int mode;
    int mode_left;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Collisions, coalesced chains, duplicates, key extremes, then fill the table
  task automatic test_directed();
    send_request(REQ_FIND,   '0);
    send_request(REQ_INSERT, '0);
    send_request(REQ_INSERT, KEY_W'(8));
    send_request(REQ_INSERT, KEY_W'(16));
    send_request(REQ_INSERT, KEY_MAX);
    send_request(REQ_INSERT, '0);
    send_request(REQ_FIND,   '0);
    send_request(REQ_FIND,   KEY_W'(16));
    send_request(REQ_FIND,   KEY_MAX);
    send_request(REQ_FIND,   KEY_W'(24));
    send_request(REQ_FIND,   KEY_W'(3));
    send_request(REQ_INSERT, KEY_W'(32'h5555_5555));
    send_request(REQ_INSERT, KEY_W'(32'h2AAA_AAAA));
    send_request(REQ_INSERT, KEY_W'(9));
    send_request(REQ_INSERT, KEY_W'(1));
    send_request(REQ_INSERT, KEY_MAX);
    send_request(REQ_FIND,   KEY_W'(9));
    send_request(REQ_FIND,   KEY_W'(32'h2AAA_AAAA));
    send_request(REQ_FIND,   KEY_W'(32'h5555_5555));
    send_request(REQ_FIND,   KEY_W'(1));
    send_request(REQ_FIND,   KEY_W'(32));
    idle_cycles(2);
    wait_drain();
  endtask

  // Hold off results for a long stretch while items keep coming
  task automatic test_output_backpressure();
    hold_request = 300;
    for (int i = 0; i < 12; i++) begin
      if (i % 2 == 0 && stored_keys.size() > 0)
        send_request(REQ_FIND, stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
      else
        send_request(i % 3 == 0 ? REQ_INSERT : REQ_FIND, random_key());
    end
    idle_cycles(1);
    wait_drain();
  endtask

  // Mostly finds of stored keys and their home-slot neighbors, in bursts
  task automatic test_random_mix(input int n_items);
    int               pick;
    int               burst_left;
    int               gap;
    bit               find_op;
    logic [KEY_W-1:0] key;
    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < n_items; i++) begin
      pick    = $urandom_range(0, 99);
      find_op = REQ_FIND;
      if (pick < 40 && stored_keys.size() > 0) begin
        key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end else if (pick < 60) begin
        key = random_key();
      end else if (pick < 75 && stored_keys.size() > 0) begin
        key = KEY_W'(stored_keys[$urandom_range(0, stored_keys.size() - 1)] +
                     TABLE_SIZE * $urandom_range(1, 1000));
      end else begin
        find_op = REQ_INSERT;
        key     = random_key();
      end
      send_request(find_op, key);
      // Pause now and then until every result is back
      if (i % 300 == 299) begin
        idle_cycles(1);
        wait_drain();
      end else if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) idle_cycles(gap);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
    idle_cycles(1);
    wait_drain();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = REQ_INSERT;
    in_key       = '0;
    hold_request = 0;
    clear_table();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_output_backpressure();
    test_random_mix(1220);

    wait_drain();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d inserts (%0d dropped on a full table) and %0d finds",
             n_insert, n_full, n_find);
    $display("Finds: %0d hits, %0d misses; %0d results checked, %0d mismatches",
             n_found, n_missing, results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
